@@ hdl/assert_macros.svh @@
// Assertion macros shared by the fader RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/lmf_pkg.sv @@
// Types, codes, constants and helpers of the lamp mode and LED fader
package lmf_pkg;

	// Switch event codes
	localparam logic [1:0] SW_OFF = 2'd1;
	localparam logic [1:0] SW_ON  = 2'd2;

	// Command codes
	localparam logic [2:0] KIND_NONE    = 3'd0;
	localparam logic [2:0] KIND_ON      = 3'd1;
	localparam logic [2:0] KIND_OFF     = 3'd2;
	localparam logic [2:0] KIND_SET_ON  = 3'd3;
	localparam logic [2:0] KIND_SET_OFF = 3'd4;

	// Target chain codes
	localparam logic [1:0] SEL_OFF = 2'd0;
	localparam logic [1:0] SEL_ON  = 2'd1;
	localparam logic [1:0] SEL_AP  = 2'd2;
	localparam logic [1:0] SEL_STA = 2'd3;

	// Register indexes
	localparam logic [1:0] REG_FADE_AMT     = 2'd0;
	localparam logic [1:0] REG_PRESS_WINDOW = 2'd1;
	localparam logic [1:0] REG_AP_TIMEOUT   = 2'd2;

	// Register reset values
	localparam logic [7:0]  FADE_AMT_RST     = 8'd5;
	localparam logic [15:0] PRESS_WINDOW_RST = 16'd150;
	localparam logic [19:0] AP_TIMEOUT_RST   = 20'd15000;

	// Press counting and tick counter limits
	localparam logic [7:0]  PRESS_MOD     = 8'd250;
	localparam logic [7:0]  PRESS_TRIGGER = 8'd3;
	localparam logic [15:0] PRESS_TICK_MAX = 16'hFFFF;
	localparam logic [19:0] AP_TICK_MAX    = 20'hFFFFF;

	// Queue depths
	localparam int JOB_DEPTH = 2;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	localparam int LED_INDEX_W = 6;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		logic active;
		rgb_t colour;
	} led_word_t;

	// Fixed chain colours and reset values of the settable on and off colours
	localparam rgb_t AP_RGB         = '{r: 8'd100, g: 8'd20,  b: 8'd20};
	localparam rgb_t STA_RGB        = '{r: 8'd20,  g: 8'd100, b: 8'd20};
	localparam rgb_t OFF_SECOND_RGB = '{r: 8'd0,   g: 8'd20,  b: 8'd20};
	localparam rgb_t ON_RGB_RST     = '{r: 8'd250, g: 8'd200, b: 8'd200};
	localparam rgb_t OFF_RGB_RST    = '{r: 8'd0,   g: 8'd0,   b: 8'd20};

	// One tick of work, handed from the front to the back
	typedef struct packed {
		logic [1:0] sel;
		rgb_t       on_colour;
		rgb_t       off_colour;
		logic       start_ap;
		logic       stop_ap;
		logic       lamp_on;
	} job_t;

	// One result beat
	typedef struct packed {
		logic                   led_valid;
		logic [LED_INDEX_W-1:0] led_index;
		rgb_t                   colour;
		logic                   led_active;
		logic                   start_ap;
		logic                   stop_ap;
		logic                   lamp_on;
		logic                   last;
	} result_t;

	// Target colour and active flag of one LED in the chosen chain
	function automatic led_word_t target_word(input logic [1:0] sel, input logic first,
			input logic second, input rgb_t on_c, input rgb_t off_c);
		led_word_t w;
		w.active = 1'b1;
		w.colour = '0;
		case (sel)
			SEL_ON:  w.colour = on_c;
			SEL_AP:  w.colour = AP_RGB;
			SEL_STA: w.colour = STA_RGB;
			default: begin
				if (first) begin
					w.colour = off_c;
				end else if (second) begin
					w.colour = OFF_SECOND_RGB;
				end else begin
					w.active = 1'b0;
				end
			end
		endcase
		return w;
	endfunction

endpackage

@@ hdl/lamp_mode_and_led_fader.sv @@
// Top level of the lamp mode logic and LED fader
//
// Use: every loop tick is pushed as one beat on the input queue (push/full)
// with the switch event, command, colour and wifi status. Results come out of
// the result queue (empty/pop): while the LED chain still differs from the
// target chain, a tick gives NUM_LEDS beats, one per LED in index order,
// otherwise one status beat. The beat with last set closes a tick.
// The front end takes a tick per cycle while its two-entry job queue has room.
// The back end walks the LED store one entry per cycle through a single read
// port, holding its update walk while the result queue has no room: a status
// tick takes one compare pass and a status beat, a fading tick a compare pass
// and an update pass. A status beat is pushed from the status state after the
// compare pass; LED beats follow the registered reads of the update pass.
// If the receiver stops popping, the four-entry result queue fills, the back
// end holds its walk, the job queue fills and full rises.
// Reset clears the mode state, the queues and the written flags of the LED
// store, so every LED reads black and inactive; no clearing pass is needed.
// Registers sit on an APB-style port: the fade step at 0x0, press_window at 0x4,
// ap_timeout at 0x8; write them only while the block is idle.
module lamp_mode_and_led_fader #(
	parameter int NUM_LEDS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  switch_event,
	input  logic [2:0]  kind,
	input  logic [7:0]  cmd_red,
	input  logic [7:0]  cmd_green,
	input  logic [7:0]  cmd_blue,
	input  logic        wifi_ap,
	input  logic        wifi_sta,
	output logic        empty,
	input  logic        pop,
	output logic        led_valid,
	output logic [5:0]  led_index,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        led_active,
	output logic        start_ap,
	output logic        stop_ap,
	output logic        lamp_on,
	output logic        last
);

	localparam int JOB_CW = $clog2(lmf_pkg::JOB_DEPTH + 1);

	logic [7:0]                    fade_amt_q;
	logic [15:0]                   press_window_q;
	logic [19:0]                   ap_timeout_q;
	logic                          cfg_wr;

	logic                          job_push;
	lmf_pkg::job_t                 job_wr;
	logic                          job_full;
	logic                          job_empty;
	logic                          job_pop;
	lmf_pkg::job_t                 job_rd;
	logic [JOB_CW-1:0]             job_count;

	logic                          res_push;
	lmf_pkg::result_t              res_wr;
	lmf_pkg::result_t              res_rd;
	logic                          res_full;
	logic [lmf_pkg::OUT_CNT_W-1:0] res_count;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_amt_q     <= lmf_pkg::FADE_AMT_RST;
			press_window_q <= lmf_pkg::PRESS_WINDOW_RST;
			ap_timeout_q   <= lmf_pkg::AP_TIMEOUT_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				lmf_pkg::REG_FADE_AMT:     fade_amt_q     <= pwdata[7:0];
				lmf_pkg::REG_PRESS_WINDOW: press_window_q <= pwdata[15:0];
				lmf_pkg::REG_AP_TIMEOUT:   ap_timeout_q   <= pwdata[19:0];
				default: begin
				end
			endcase
		end
	end

	// Register reads
	always_comb begin
		case (paddr[3:2])
			lmf_pkg::REG_FADE_AMT:     prdata = {24'd0, fade_amt_q};
			lmf_pkg::REG_PRESS_WINDOW: prdata = {16'd0, press_window_q};
			lmf_pkg::REG_AP_TIMEOUT:   prdata = {12'd0, ap_timeout_q};
			default:                   prdata = '0;
		endcase
	end

	lmf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.press_window (press_window_q),
		.ap_timeout   (ap_timeout_q),
		.push         (push),
		.full         (full),
		.switch_event (switch_event),
		.kind         (kind),
		.cmd_red      (cmd_red),
		.cmd_green    (cmd_green),
		.cmd_blue     (cmd_blue),
		.wifi_ap      (wifi_ap),
		.wifi_sta     (wifi_sta),
		.job_push     (job_push),
		.job          (job_wr),
		.job_full     (job_full)
	);

	lmf_queue #(
		.WIDTH ($bits(lmf_pkg::job_t)),
		.DEPTH (lmf_pkg::JOB_DEPTH)
	) u_job_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_wr),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (job_rd),
		.empty  (job_empty),
		.count  (job_count)
	);

	lmf_back #(
		.NUM_LEDS (NUM_LEDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fade_amt  (fade_amt_q),
		.job_empty (job_empty),
		.job_in    (job_rd),
		.job_pop   (job_pop),
		.res_push  (res_push),
		.res       (res_wr),
		.out_count (res_count)
	);

	lmf_queue #(
		.WIDTH ($bits(lmf_pkg::result_t)),
		.DEPTH (lmf_pkg::OUT_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wr),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rd),
		.empty  (empty),
		.count  (res_count)
	);

	// Unpack the oldest result onto the ports
	assign led_valid  = res_rd.led_valid;
	assign led_index  = res_rd.led_index;
	assign red        = res_rd.colour.r;
	assign green      = res_rd.colour.g;
	assign blue       = res_rd.colour.b;
	assign led_active = res_rd.led_active;
	assign start_ap   = res_rd.start_ap;
	assign stop_ap    = res_rd.stop_ap;
	assign lamp_on    = res_rd.lamp_on;
	assign last       = res_rd.last;

	`include "assert_macros.svh"
	`ASSERT_IMPLY(a_job_count_full, job_full, job_count == JOB_CW'(lmf_pkg::JOB_DEPTH), "job full flag wrong")
	`ASSERT_IMPLY(a_res_full_no_push, res_full, !res_push, "result pushed while queue full")

endmodule

@@ hdl/lmf_queue.sv @@
// Small first-in first-out queue built from registers
`include "assert_macros.svh"

module lmf_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	output logic                       full,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_ALWAYS(a_queue_count_range, count_q <= CW'(DEPTH), "queue fill count beyond depth")
	`ASSERT_NEXT(a_queue_push_only, do_push && !do_pop, !empty, "queue empty after a lone push")

endmodule

@@ hdl/lmf_front.sv @@
// Front end: takes ticks, runs the lamp mode logic and issues fade jobs
`include "assert_macros.svh"

module lmf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [15:0]       press_window,
	input  logic [19:0]       ap_timeout,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        switch_event,
	input  logic [2:0]        kind,
	input  logic [7:0]        cmd_red,
	input  logic [7:0]        cmd_green,
	input  logic [7:0]        cmd_blue,
	input  logic              wifi_ap,
	input  logic              wifi_sta,
	output logic              job_push,
	output lmf_pkg::job_t     job,
	input  logic              job_full
);

	logic              lamp_q;
	logic [1:0]        sel_q;
	lmf_pkg::rgb_t     on_colour_q;
	lmf_pkg::rgb_t     off_colour_q;
	logic [7:0]        press_count_q;
	logic [15:0]       ticks_press_q;
	logic [19:0]       ticks_ap_q;

	logic              lamp_n;
	logic [1:0]        sel_n;
	lmf_pkg::rgb_t     on_n;
	lmf_pkg::rgb_t     off_n;
	logic [7:0]        press_n;
	logic [15:0]       ticks_press_n;
	logic [19:0]       ticks_ap_n;
	logic              start_n;
	logic              stop_n;
	lmf_pkg::rgb_t     cmd_rgb;
	logic              accept;

	assign full     = job_full;
	assign accept   = push && !job_full;
	assign job_push = accept;
	assign cmd_rgb  = '{r: cmd_red, g: cmd_green, b: cmd_blue};

	// Work out the mode state after this tick
	always_comb begin
		lamp_n        = lamp_q;
		sel_n         = sel_q;
		on_n          = on_colour_q;
		off_n         = off_colour_q;
		press_n       = press_count_q;
		ticks_press_n = ticks_press_q;
		ticks_ap_n    = ticks_ap_q;
		start_n       = 1'b0;

		// Physical switch
		if (switch_event == lmf_pkg::SW_OFF) begin
			lamp_n = 1'b0;
			sel_n  = lmf_pkg::SEL_OFF;
		end else if (switch_event == lmf_pkg::SW_ON) begin
			lamp_n = 1'b1;
			sel_n  = lmf_pkg::SEL_ON;
			if (ticks_press_q < press_window) begin
				press_n = (press_count_q == lmf_pkg::PRESS_MOD - 8'd1) ? 8'd0 :
					press_count_q + 8'd1;
			end else begin
				press_n = 8'd1;
			end
			ticks_press_n = '0;
			if (press_n >= lmf_pkg::PRESS_TRIGGER && !wifi_ap && !wifi_sta) begin
				start_n    = 1'b1;
				ticks_ap_n = '0;
				sel_n      = lmf_pkg::SEL_AP;
			end else if (press_n >= lmf_pkg::PRESS_TRIGGER && wifi_sta) begin
				sel_n = lmf_pkg::SEL_STA;
			end
		end

		// Command
		case (kind)
			lmf_pkg::KIND_ON: begin
				lamp_n = 1'b1;
				sel_n  = lmf_pkg::SEL_ON;
			end
			lmf_pkg::KIND_OFF: begin
				lamp_n = 1'b0;
				sel_n  = lmf_pkg::SEL_OFF;
			end
			lmf_pkg::KIND_SET_ON: begin
				on_n   = cmd_rgb;
				lamp_n = 1'b1;
				sel_n  = lmf_pkg::SEL_ON;
			end
			lmf_pkg::KIND_SET_OFF: begin
				off_n  = cmd_rgb;
				lamp_n = 1'b0;
				sel_n  = lmf_pkg::SEL_OFF;
			end
			default: begin
			end
		endcase

		// Access point idle timer
		if (wifi_ap && kind != lmf_pkg::KIND_NONE) begin
			ticks_ap_n = '0;
		end
		stop_n = wifi_ap && (ticks_ap_n > ap_timeout);
	end

	// Job for the back end
	always_comb begin
		job.sel        = sel_n;
		job.on_colour  = on_n;
		job.off_colour = off_n;
		job.start_ap   = start_n;
		job.stop_ap    = stop_n;
		job.lamp_on    = lamp_n;
	end

	// Commit the mode state on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lamp_q        <= 1'b0;
			sel_q         <= lmf_pkg::SEL_OFF;
			on_colour_q   <= lmf_pkg::ON_RGB_RST;
			off_colour_q  <= lmf_pkg::OFF_RGB_RST;
			press_count_q <= '0;
			ticks_press_q <= '0;
			ticks_ap_q    <= '0;
		end else if (accept) begin
			lamp_q        <= lamp_n;
			sel_q         <= sel_n;
			on_colour_q   <= on_n;
			off_colour_q  <= off_n;
			press_count_q <= press_n;
			ticks_press_q <= (ticks_press_n == lmf_pkg::PRESS_TICK_MAX) ? ticks_press_n :
				ticks_press_n + 16'd1;
			ticks_ap_q    <= (ticks_ap_n == lmf_pkg::AP_TICK_MAX) ? ticks_ap_n :
				ticks_ap_n + 20'd1;
		end
	end

	`ASSERT_ALWAYS(a_press_count_range, press_count_q < lmf_pkg::PRESS_MOD, "press count out of range")
	`ASSERT_NEXT(a_start_clears_timer, accept && start_n, ticks_ap_q == 20'd1, "AP timer not restarted")

endmodule

@@ hdl/lmf_back.sv @@
// Back end: walks the LED chain, compares, fades and emits result beats
`include "assert_macros.svh"

module lmf_back #(
	parameter int NUM_LEDS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [7:0]                    fade_amt,
	input  logic                          job_empty,
	input  lmf_pkg::job_t                 job_in,
	output logic                          job_pop,
	output logic                          res_push,
	output lmf_pkg::result_t              res,
	input  logic [lmf_pkg::OUT_CNT_W-1:0] out_count
);

	localparam int IW = $clog2(NUM_LEDS);
	localparam int CW = lmf_pkg::OUT_CNT_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;
	localparam logic [1:0] S_STAT = 2'd3;

	logic [1:0]           state_q;
	lmf_pkg::job_t        job_q;
	logic                 differs_q;
	logic [IW-1:0]        rd_idx_q;
	logic                 rd_done_q;

	// LED store and its written flags
	lmf_pkg::led_word_t   led_mem_q [NUM_LEDS];
	logic [NUM_LEDS-1:0]  written_q;

	// Read stage
	logic                 v_s1;
	logic [IW-1:0]        idx_s1;
	lmf_pkg::led_word_t   word_s1;
	logic                 wvld_s1;

	logic                 rd_en;
	logic                 out_room_upd;
	logic                 out_room;
	logic                 last_led;
	logic                 wr_en;
	lmf_pkg::led_word_t   actual;
	lmf_pkg::led_word_t   target;
	lmf_pkg::led_word_t   faded;

	function automatic logic [7:0] move_toward(input logic [7:0] a, input logic [7:0] d,
			input logic [7:0] step);
		logic [7:0] diff;
		diff = (d > a) ? d - a : a - d;
		if (diff < step) begin
			return d;
		end
		return (d > a) ? a + step : a - step;
	endfunction

	function automatic logic [7:0] move_down(input logic [7:0] a, input logic [7:0] step);
		return (a < step) ? 8'd0 : a - step;
	endfunction

	assign out_room_upd = ((CW+1)'(out_count) + (CW+1)'(v_s1)) < (CW+1)'(lmf_pkg::OUT_DEPTH);
	assign out_room     = out_count < CW'(lmf_pkg::OUT_DEPTH);
	assign rd_en        = !rd_done_q &&
		((state_q == S_CMP) || ((state_q == S_UPD) && out_room_upd));
	assign job_pop      = (state_q == S_IDLE) && !job_empty;
	assign last_led     = (idx_s1 == IW'(NUM_LEDS - 1));
	assign wr_en        = (state_q == S_UPD) && v_s1;

	// Stored word, or zero where the LED was never written
	assign actual = wvld_s1 ? word_s1 : '0;
	assign target = lmf_pkg::target_word(job_q.sel, idx_s1 == '0, idx_s1 == IW'(1),
		job_q.on_colour, job_q.off_colour);

	// Fade one LED toward its target
	always_comb begin
		if (target.active) begin
			faded.colour.r = move_toward(actual.colour.r, target.colour.r, fade_amt);
			faded.colour.g = move_toward(actual.colour.g, target.colour.g, fade_amt);
			faded.colour.b = move_toward(actual.colour.b, target.colour.b, fade_amt);
		end else begin
			faded.colour.r = move_down(actual.colour.r, fade_amt);
			faded.colour.g = move_down(actual.colour.g, fade_amt);
			faded.colour.b = move_down(actual.colour.b, fade_amt);
		end
		faded.active = (faded.colour.r >= fade_amt) || (faded.colour.g >= fade_amt) ||
			(faded.colour.b >= fade_amt);
	end

	// Build the result beat
	always_comb begin
		res_push       = wr_en || ((state_q == S_STAT) && out_room);
		res.start_ap   = job_q.start_ap;
		res.stop_ap    = job_q.stop_ap;
		res.lamp_on    = job_q.lamp_on;
		if (state_q == S_UPD) begin
			res.led_valid  = 1'b1;
			res.led_index  = lmf_pkg::LED_INDEX_W'(idx_s1);
			res.colour     = faded.colour;
			res.led_active = faded.active;
			res.last       = last_led;
		end else begin
			res.led_valid  = 1'b0;
			res.led_index  = '0;
			res.colour     = '0;
			res.led_active = 1'b0;
			res.last       = 1'b1;
		end
	end

	// LED store: one read and one write port, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			led_mem_q[idx_s1] <= faded;
		end
		if (rd_en) begin
			word_s1 <= led_mem_q[rd_idx_q];
			idx_s1  <= rd_idx_q;
		end
	end

	// Mark written LEDs and register the flag alongside the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			wvld_s1   <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[idx_s1] <= 1'b1;
			end
			if (rd_en) begin
				wvld_s1 <= written_q[rd_idx_q];
			end
		end
	end

	// Sequencer: compare pass, then update pass or status beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			job_q     <= '0;
			differs_q <= 1'b0;
			rd_idx_q  <= '0;
			rd_done_q <= 1'b0;
			v_s1      <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
				if (rd_idx_q == IW'(NUM_LEDS - 1)) begin
					rd_done_q <= 1'b1;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (!job_empty) begin
						job_q     <= job_in;
						differs_q <= 1'b0;
						rd_idx_q  <= '0;
						rd_done_q <= 1'b0;
						state_q   <= S_CMP;
					end
				end
				S_CMP: begin
					if (v_s1) begin
						if (last_led) begin
							state_q   <= (differs_q || (actual != target)) ? S_UPD : S_STAT;
							rd_idx_q  <= '0;
							rd_done_q <= 1'b0;
						end else begin
							differs_q <= differs_q || (actual != target);
						end
					end
				end
				S_UPD: begin
					if (v_s1 && last_led) begin
						state_q <= S_IDLE;
					end
				end
				S_STAT: begin
					if (out_room) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_IMPLY(a_out_has_room, res_push, out_count < CW'(lmf_pkg::OUT_DEPTH), "push into full")
	`ASSERT_IMPLY(a_read_stage_state, v_s1, state_q == S_CMP || state_q == S_UPD, "stray read")

endmodule
